// ===== sv/tsq_pkg.sv =====
// -----------------------------------------------------------------------------
// tsq_pkg
// Shared types and constants of the triggered stepper task queue.
// -----------------------------------------------------------------------------
package tsq_pkg;

  localparam int unsigned TSQ_RING_SLOTS = 16;
  localparam int unsigned TSQ_LINK_DEPTH = 2;
  localparam int unsigned NUM_SENSORS    = 3;
  localparam int unsigned APB_ADDR_W     = 4;
  localparam int unsigned APB_DATA_W     = 32;

  localparam logic [15:0] DEBOUNCE_RESET      = 16'd200;
  localparam logic [7:0]  STEP_PERIOD_RESET   = 8'd2;
  localparam logic [15:0] STEPS_PER_REV_RESET = 16'd1024;

  typedef enum logic [1:0] {
    REG_DEBOUNCE      = 2'd0,
    REG_STEP_PERIOD   = 2'd1,
    REG_STEPS_PER_REV = 2'd2
  } cfg_reg_e;

  // One tick as classified by the front end
  typedef struct packed {
    logic [31:0]            now;
    logic [NUM_SENSORS-1:0] fire;
  } tick_t;

endpackage

// ===== sv/tsq_in_if.sv =====
// -----------------------------------------------------------------------------
// tsq_in_if
// Tick channel: valid/ready handshake with three active-low sensor levels.
// -----------------------------------------------------------------------------
interface tsq_in_if;
  logic valid;
  logic ready;
  logic sensor_one_n;
  logic sensor_two_n;
  logic sensor_three_n;

  modport source (output valid, output sensor_one_n, output sensor_two_n,
                  output sensor_three_n, input ready);
  modport sink   (input valid, input sensor_one_n, input sensor_two_n,
                  input sensor_three_n, output ready);
endinterface

// ===== sv/tsq_out_if.sv =====
// -----------------------------------------------------------------------------
// tsq_out_if
// Result channel: valid/ready handshake with the per-tick status.
// -----------------------------------------------------------------------------
interface tsq_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] coil_pattern;
  logic [1:0] shown_frame;
  logic       busy_res;
  logic [3:0] queued_jobs;
  logic       job_dropped;

  modport source (output valid, output coil_pattern, output shown_frame,
                  output busy_res, output queued_jobs, output job_dropped,
                  input ready);
  modport sink   (input valid, input coil_pattern, input shown_frame,
                  input busy_res, input queued_jobs, input job_dropped,
                  output ready);
endinterface

// ===== sv/tsq_front.sv =====
// -----------------------------------------------------------------------------
// tsq_front
// Tick front end: keeps the millisecond clock and debounces the sensors.
// -----------------------------------------------------------------------------
module tsq_front import tsq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsq_in_if.sink      in_i,
  input  logic [15:0] debounce_ms_i,
  output tick_t       tick_o,
  output logic        tick_valid_o,
  input  logic        tick_ready_i
);

  logic [31:0]            time_now_q, time_now_d;
  logic [31:0]            last_fire_q [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] sensors_n;
  logic [NUM_SENSORS-1:0] fire;
  logic                   accept;

  assign sensors_n = {in_i.sensor_three_n, in_i.sensor_two_n, in_i.sensor_one_n};

  always_comb begin
    for (int k = 0; k < NUM_SENSORS; k++) begin
      fire[k] = !sensors_n[k] &&
                ((time_now_q - last_fire_q[k]) > {16'd0, debounce_ms_i});
    end
  end

  assign in_i.ready   = tick_ready_i;
  assign tick_valid_o = in_i.valid;
  assign accept       = in_i.valid && tick_ready_i;
  assign tick_o.now   = time_now_q;
  assign tick_o.fire  = fire;
  assign time_now_d   = time_now_q + 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_now_q <= '0;
      for (int k = 0; k < NUM_SENSORS; k++) begin
        last_fire_q[k] <= '0;
      end
    end else if (accept) begin
      time_now_q <= time_now_d;
      for (int k = 0; k < NUM_SENSORS; k++) begin
        // a firing counts for debounce even when its job is dropped
        if (fire[k]) begin
          last_fire_q[k] <= time_now_q;
        end
      end
    end
  end

endmodule

// ===== sv/tsq_link.sv =====
// -----------------------------------------------------------------------------
// tsq_link
// Short queue of classified ticks between the front end and the job engine.
// -----------------------------------------------------------------------------
module tsq_link import tsq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  tick_t wr_data_i,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  output tick_t rd_data_o,
  output logic  rd_valid_o,
  input  logic  rd_ready_i
);

  localparam int unsigned PW = (TSQ_LINK_DEPTH > 1) ? $clog2(TSQ_LINK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TSQ_LINK_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(TSQ_LINK_DEPTH - 1);

  tick_t         slot_q [TSQ_LINK_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          push, pop;

  assign wr_ready_o = (count_q != CW'(TSQ_LINK_DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = slot_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/tsq_back.sv =====
// -----------------------------------------------------------------------------
// tsq_back
// Job engine: job ring, job start, wave-drive stepping and the result register.
// -----------------------------------------------------------------------------
module tsq_back import tsq_pkg::*; #(
  parameter int unsigned RING_SLOTS = TSQ_RING_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tick_t       tick_i,
  input  logic        tick_valid_i,
  output logic        tick_ready_o,
  input  logic [7:0]  step_period_ms_i,
  input  logic [15:0] steps_per_rev_i,
  tsq_out_if.source   out_o
);

  localparam int unsigned IW = $clog2(RING_SLOTS);
  localparam logic [IW-1:0] LAST = IW'(RING_SLOTS - 1);

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
    return (idx == LAST) ? '0 : IW'(idx + 1'b1);
  endfunction

  logic [1:0]    ring_q [RING_SLOTS];
  logic [1:0]    ring_d [RING_SLOTS];
  logic [IW-1:0] head_q, head_d, tail_q, tail_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] wslot [4];
  logic          active_q, active_d;
  logic [17:0]   rem_q, rem_d;
  logic [1:0]    frame_q, frame_d;
  logic [3:0]    coils_q, coils_d;
  logic [1:0]    phase_q, phase_d;
  logic [31:0]   last_step_q, last_step_d;
  logic          out_valid_q;
  logic [3:0]    queued_q, queued_d;
  logic          dropped_q, dropped_d;
  logic          proceed;

  logic [IW:0]   fill;
  logic [1:0]    acc;
  logic [1:0]    first_job;
  logic [1:0]    job;
  logic [31:0]   fill_ext;

  assign tick_ready_o = !out_valid_q || out_o.ready;
  assign proceed      = tick_valid_i && tick_ready_o;

  always_comb begin
    ring_d      = ring_q;
    head_d      = head_q;
    active_d    = active_q;
    rem_d       = rem_q;
    frame_d     = frame_q;
    coils_d     = coils_q;
    phase_d     = phase_q;
    last_step_d = last_step_q;
    dropped_d   = 1'b0;
    first_job   = '0;
    job         = '0;
    acc         = '0;
    fill        = {1'b0, cnt_q};

    wslot[0] = tail_q;
    wslot[1] = ring_next(wslot[0]);
    wslot[2] = ring_next(wslot[1]);
    wslot[3] = ring_next(wslot[2]);

    // enqueue firings in sensor order while the ring has room
    for (int k = 0; k < NUM_SENSORS; k++) begin
      if (tick_i.fire[k]) begin
        if (fill < (IW+1)'(RING_SLOTS - 1)) begin
          ring_d[wslot[acc]] = 2'(k + 1);
          if (acc == 2'd0) begin
            first_job = 2'(k + 1);
          end
          acc  = acc + 2'd1;
          fill = fill + 1'b1;
        end else begin
          dropped_d = 1'b1;
        end
      end
    end
    tail_d = wslot[acc];

    // start the oldest job; bypass the ring when it was empty before this tick
    if (!active_q && (fill != '0)) begin
      job      = (cnt_q == '0) ? first_job : ring_q[head_q];
      head_d   = ring_next(head_q);
      fill     = fill - 1'b1;
      active_d = 1'b1;
      frame_d  = job;
      rem_d    = 18'(job) * {2'b00, steps_per_rev_i};
    end

    if (active_d) begin
      if (rem_d != '0) begin
        if ((tick_i.now - last_step_q) >= {24'd0, step_period_ms_i}) begin
          last_step_d = tick_i.now;
          coils_d     = 4'b0001 << phase_q;
          phase_d     = phase_q + 2'd1;
          rem_d       = rem_d - 18'd1;
        end
      end else begin
        frame_d  = '0;
        active_d = 1'b0;
      end
    end

    cnt_d    = fill[IW-1:0];
    fill_ext = 32'(fill);
    queued_d = (fill_ext > 32'd15) ? 4'd15 : fill_ext[3:0];
  end

  always_ff @(posedge clk_i) begin
    if (proceed) begin
      ring_q <= ring_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      active_q    <= 1'b0;
      rem_q       <= '0;
      frame_q     <= '0;
      coils_q     <= '0;
      phase_q     <= '0;
      last_step_q <= '0;
      queued_q    <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (proceed) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        cnt_q       <= cnt_d;
        active_q    <= active_d;
        rem_q       <= rem_d;
        frame_q     <= frame_d;
        coils_q     <= coils_d;
        phase_q     <= phase_d;
        last_step_q <= last_step_d;
        queued_q    <= queued_d;
        dropped_q   <= dropped_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // the state registers double as the result register: they only move
  // when the previous result has gone
  assign out_o.valid        = out_valid_q;
  assign out_o.coil_pattern = coils_q;
  assign out_o.shown_frame  = frame_q;
  assign out_o.busy_res     = active_q;
  assign out_o.queued_jobs  = queued_q;
  assign out_o.job_dropped  = dropped_q;

endmodule

// ===== sv/triggered_stepper_task_queue.sv =====
// -----------------------------------------------------------------------------
// triggered_stepper_task_queue
// Debounced light-barrier triggers feeding a job ring that drives a stepper.
// -----------------------------------------------------------------------------
// Usage:
//   in_i  carries one millisecond tick per transaction with three active-low
//         sensor levels; out_o returns one status transaction per tick
//         (coil drive, shown frame, busy, queued jobs, drop flag).
//   The front end debounces the sensors and hands the tick through a
//   two-entry queue to the job engine, which updates the ring and the motor
//   and writes the result register.
//   Throughput: one tick per clock cycle while the receiver takes every result.
//   A tick accepted on in_i is written into the two-entry queue and then taken
//   by the job engine into the result register, provided that register is free.
//   When the receiver stalls, the result is held, the queue fills and in_i
//   drops ready once the queue holds two ticks; nothing is lost.
//   Reset clears the clock, the debounce times, the ring pointers and the
//   motor state and loads the register defaults (debounce 200 ms, step
//   period 2 ms, 1024 steps per revolution).
//   Registers (APB, byte address 4*i): 0 debounce_ms, 1 step_period_ms,
//   2 steps_per_rev. Write them only while no tick is in flight.
// -----------------------------------------------------------------------------
module triggered_stepper_task_queue import tsq_pkg::*; #(
  parameter int unsigned RING_SLOTS = TSQ_RING_SLOTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tsq_in_if.sink                in_i,
  tsq_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [15:0] debounce_q;
  logic [7:0]  step_period_q;
  logic [15:0] steps_per_rev_q;
  logic        cfg_write;

  tick_t front_tick, back_tick;
  logic  front_valid, front_ready, back_valid, back_ready;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q      <= DEBOUNCE_RESET;
      step_period_q   <= STEP_PERIOD_RESET;
      steps_per_rev_q <= STEPS_PER_REV_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_DEBOUNCE:      debounce_q      <= pwdata[15:0];
        REG_STEP_PERIOD:   step_period_q   <= pwdata[7:0];
        REG_STEPS_PER_REV: steps_per_rev_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DEBOUNCE:      prdata = {16'd0, debounce_q};
      REG_STEP_PERIOD:   prdata = {24'd0, step_period_q};
      REG_STEPS_PER_REV: prdata = {16'd0, steps_per_rev_q};
      default:           prdata = '0;
    endcase
  end

  tsq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .debounce_ms_i (debounce_q),
    .tick_o        (front_tick),
    .tick_valid_o  (front_valid),
    .tick_ready_i  (front_ready)
  );

  tsq_link u_link (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_data_i  (front_tick),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .rd_data_o  (back_tick),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready)
  );

  tsq_back #(
    .RING_SLOTS (RING_SLOTS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_i           (back_tick),
    .tick_valid_i     (back_valid),
    .tick_ready_o     (back_ready),
    .step_period_ms_i (step_period_q),
    .steps_per_rev_i  (steps_per_rev_q),
    .out_o            (out_o)
  );

  // an idle engine always shows a cleared display
  ap_idle_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.busy_res) |-> (out_o.shown_frame == 2'd0))
    else $error("idle result shows a frame");

  // a running job always shows its job number
  ap_busy_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.busy_res) |-> (out_o.shown_frame != 2'd0))
    else $error("running job shows a cleared display");

  // wave drive energises at most one coil
  ap_wave_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> $onehot0(out_o.coil_pattern))
    else $error("more than one coil driven");

  // a result can only follow a tick taken from the queue
  ap_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_o.valid && !(back_valid && back_ready)) |=> !out_o.valid)
    else $error("result without a tick");

endmodule

// ===== dv/tb_triggered_stepper_task_queue.sv =====
// -----------------------------------------------------------------------------
// tb_triggered_stepper_task_queue
// Self-checking bench for the triggered stepper task queue.
// Sends millisecond ticks with active-low sensor levels and predicts each
// status transaction from its own model of the debounce, the job ring and the
// wave-drive stepper. Every result is compared field by field against the
// oldest prediction. Registers are reprogrammed over APB between phases.
// -----------------------------------------------------------------------------
module tb_triggered_stepper_task_queue import tsq_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_TICKS   = 130;
  localparam logic [1:0]  REG_SPARE_IDX = 2'd3;  // unmapped slot, writes ignored

  typedef struct packed {
    logic [3:0] coil;
    logic [1:0] frame;
    logic       busy;
    logic [3:0] queued;
    logic       dropped;
  } status_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tsq_in_if  tick_if ();
  tsq_out_if status_if ();

  triggered_stepper_task_queue uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (tick_if),
    .out_o   (status_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Stepper model state
  logic [15:0] cfg_debounce;
  logic [7:0]  cfg_step_period;
  logic [15:0] cfg_steps_rev;
  logic [31:0] ms_now;
  logic [31:0] fired_at [NUM_SENSORS];
  logic [31:0] stepped_at;
  logic [1:0]  coil_phase;
  logic [1:0]  ring_jobs [TSQ_RING_SLOTS];
  int unsigned ring_rd;
  int unsigned ring_wr;
  logic        running;
  logic [17:0] steps_left;
  logic [3:0]  held_coils;
  logic [1:0]  frame_shown;

  status_t     expected_status [$];
  int unsigned ticks_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned drops_expected;
  int unsigned peak_queue;
  int unsigned cfg_writes;
  int unsigned cycle_cnt;

  // Sender and receiver pacing
  bit          gaps_on;
  int unsigned burst_left;
  logic [2:0]  sensor_lvl;
  int unsigned sensor_run [NUM_SENSORS];
  logic [31:0] stall_word;
  logic [4:0]  stall_pos;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cfg_debounce    = DEBOUNCE_RESET;
    cfg_step_period = STEP_PERIOD_RESET;
    cfg_steps_rev   = STEPS_PER_REV_RESET;
    ms_now          = '0;
    for (int k = 0; k < NUM_SENSORS; k++) fired_at[k] = '0;
    for (int k = 0; k < NUM_SENSORS; k++) sensor_run[k] = 0;
    stepped_at      = '0;
    coil_phase      = '0;
    ring_rd         = 0;
    ring_wr         = 0;
    running         = 1'b0;
    steps_left      = '0;
    held_coils      = '0;
    frame_shown     = '0;
    ticks_sent      = 0;
    results_seen    = 0;
    mismatches      = 0;
    drops_expected  = 0;
    peak_queue      = 0;
    cfg_writes      = 0;
    cycle_cnt       = 0;
    gaps_on         = 1'b1;
    burst_left      = 0;
    sensor_lvl      = 3'b111;
    stall_word      = '1;
    stall_pos       = '0;
  end

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatches++;
    $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // One millisecond of the stepper: debounce, enqueue, dispatch, step
  function automatic status_t advance_millisecond(input logic [2:0] lvl_n);
    status_t     res;
    logic [31:0] now;
    logic        dropped;
    logic [1:0]  job;
    int unsigned nxt;
    int unsigned cnt;
    now     = ms_now;
    dropped = 1'b0;
    for (int k = 0; k < NUM_SENSORS; k++) begin
      if (!lvl_n[k] && (now - fired_at[k]) > {16'd0, cfg_debounce}) begin
        nxt = (ring_wr + 1) % TSQ_RING_SLOTS;
        if (nxt == ring_rd) begin
          dropped = 1'b1;
        end else begin
          ring_jobs[ring_wr] = 2'(k + 1);
          ring_wr = nxt;
        end
        fired_at[k] = now;
      end
    end
    if (!running && ring_rd != ring_wr) begin
      job         = ring_jobs[ring_rd];
      ring_rd     = (ring_rd + 1) % TSQ_RING_SLOTS;
      running     = 1'b1;
      frame_shown = job;
      steps_left  = job * cfg_steps_rev;
    end
    if (running) begin
      if (steps_left != 0) begin
        if ((now - stepped_at) >= {24'd0, cfg_step_period}) begin
          stepped_at = now;
          held_coils = 4'b0001 << coil_phase;
          coil_phase = coil_phase + 2'd1;
          steps_left = steps_left - 18'd1;
        end
      end else begin
        frame_shown = '0;
        running     = 1'b0;
      end
    end
    ms_now = now + 32'd1;
    cnt = (ring_wr + TSQ_RING_SLOTS - ring_rd) % TSQ_RING_SLOTS;
    res.coil    = held_coils;
    res.frame   = frame_shown;
    res.busy    = running;
    res.queued  = (cnt > 15) ? 4'd15 : 4'(cnt);
    res.dropped = dropped;
    return res;
  endfunction

  // Tick acceptance feeds the model; result acceptance is checked
  always @(posedge clk_i) begin
    status_t seen;
    status_t want;
    if (rst_ni) begin
      if (status_if.valid === 1'b1 && status_if.ready === 1'b1) begin
        seen = {status_if.coil_pattern, status_if.shown_frame, status_if.busy_res,
                status_if.queued_jobs, status_if.job_dropped};
        results_seen++;
        if (expected_status.size() == 0) begin
          flag_mismatch("result with no tick outstanding", 1, 0);
        end else begin
          want = expected_status.pop_front();
          if (seen.coil !== want.coil) flag_mismatch("coil_pattern", seen.coil, want.coil);
          if (seen.frame !== want.frame) flag_mismatch("shown_frame", seen.frame, want.frame);
          if (seen.busy !== want.busy) flag_mismatch("busy_res", seen.busy, want.busy);
          if (seen.queued !== want.queued)
            flag_mismatch("queued_jobs", seen.queued, want.queued);
          if (seen.dropped !== want.dropped)
            flag_mismatch("job_dropped", seen.dropped, want.dropped);
        end
      end
      if (tick_if.valid === 1'b1 && tick_if.ready === 1'b1) begin
        want = advance_millisecond({tick_if.sensor_three_n, tick_if.sensor_two_n,
                                    tick_if.sensor_one_n});
        expected_status.push_back(want);
        if (want.dropped) drops_expected++;
        if (want.queued > peak_queue) peak_queue = want.queued;
      end
    end
  end

  // Receiver stalls follow a 32-bit word refreshed at random
  always @(posedge clk_i) begin
    if (stall_pos == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_word = '1;
        1:       stall_word = $urandom | $urandom;
        2:       stall_word = $urandom;
        default: stall_word = $urandom & $urandom;
      endcase
    end
    status_if.ready <= stall_word[stall_pos];
    stall_pos = stall_pos + 5'd1;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_tick(input logic [2:0] lvl_n);
    int unsigned gap;
    tick_if.valid          <= 1'b1;
    tick_if.sensor_one_n   <= lvl_n[0];
    tick_if.sensor_two_n   <= lvl_n[1];
    tick_if.sensor_three_n <= lvl_n[2];
    do @(posedge clk_i); while (tick_if.ready !== 1'b1);
    ticks_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        tick_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Hold the sender until every outstanding result is back
  task automatic wait_drained();
    tick_if.valid <= 1'b0;
    while (results_seen < ticks_sent) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] word);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_DEBOUNCE:      cfg_debounce    = word[15:0];
      REG_STEP_PERIOD:   cfg_step_period = word[7:0];
      REG_STEPS_PER_REV: cfg_steps_rev   = word[15:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Upper data bits carry junk half the time; the registers must mask it
  task automatic program_phase(input logic [15:0] db, input logic [7:0] sp,
                               input logic [15:0] spr);
    write_register(REG_DEBOUNCE, {($urandom_range(0, 1) ? 16'($urandom) : 16'h0), db});
    write_register(REG_STEP_PERIOD, {($urandom_range(0, 1) ? 24'($urandom) : 24'h0), sp});
    write_register(REG_STEPS_PER_REV, {($urandom_range(0, 1) ? 16'($urandom) : 16'h0), spr});
  endtask

  // Beam-break pulses: short low runs between high stretches, with some noise
  function automatic logic [2:0] next_levels(input int unsigned hi_max);
    logic [2:0] lvl;
    for (int k = 0; k < NUM_SENSORS; k++) begin
      if (sensor_run[k] == 0) begin
        sensor_lvl[k] = ~sensor_lvl[k];
        sensor_run[k] = sensor_lvl[k] ? $urandom_range(1, hi_max + 1) : $urandom_range(1, 6);
      end
      sensor_run[k]--;
      lvl[k] = sensor_lvl[k];
      if ($urandom_range(0, 19) == 0) lvl[k] = 1'($urandom_range(0, 1));
    end
    return lvl;
  endfunction

  // Reset values: nothing may fire inside the first debounce window
  task automatic test_power_on_defaults();
    send_tick(3'b111);
    send_tick(3'b000);
    send_tick(3'b111);
  endtask

  task automatic test_trigger_and_overflow();
    program_phase(16'd0, 8'd1, 16'd1);
    send_tick(3'b110);
    send_tick(3'b101);
    send_tick(3'b011);
    // flood all three sensors until the ring overflows
    repeat (6) send_tick(3'b000);
    repeat (3) send_tick(3'b111);
  endtask

  // Zero steps per revolution finishes a job on the tick it starts;
  // zero step period steps every tick
  task automatic test_zero_length_jobs();
    program_phase(16'd0, 8'd0, 16'd0);
    send_tick(3'b000);
    send_tick(3'b000);
    send_tick(3'b111);
    send_tick(3'b111);
    program_phase(16'd0, 8'd0, 16'd1);
    send_tick(3'b000);
    send_tick(3'b111);
  endtask

  task automatic test_register_extremes();
    program_phase(16'hFFFF, 8'hFF, 16'd3);
    repeat (3) send_tick(3'b000);
  endtask

  task automatic test_random_traffic();
    int unsigned hi_max;
    int unsigned n;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      n = PHASE_TICKS;
      if (ph == RANDOM_PHASES - 1) begin
        // longest jobs go last so they cannot starve the earlier phases
        program_phase(16'd0, 8'hFF, 16'hFFFF);
        hi_max = 10;
        n = 60;
      end else begin
        case (ph % 5)
          0: begin
            program_phase(16'($urandom_range(0, 30)), 8'($urandom_range(1, 4)),
                          16'($urandom_range(1, 6)));
            hi_max = 30;
          end
          1: begin
            program_phase(16'd0, 8'd1, 16'd1);
            hi_max = 3;
          end
          2: begin
            program_phase(16'($urandom_range(0, 5)), 8'd0, 16'($urandom_range(0, 2)));
            hi_max = 12;
          end
          3: begin
            program_phase(16'hFFFF, 8'($urandom_range(128, 255)), 16'd2);
            hi_max = 8;
          end
          default: begin
            program_phase(16'($urandom_range(0, 200)), 8'($urandom_range(0, 10)),
                          16'($urandom_range(1, 16)));
            hi_max = $urandom_range(2, 60);
          end
        endcase
      end
      if (ph == 0) write_register(REG_SPARE_IDX, $urandom);
      gaps_on = ($urandom_range(0, 2) != 0);
      for (int i = 0; i < n; i++) begin
        if (ph == RANDOM_PHASES / 2 && i == n / 2) wait_drained();
        send_tick(next_levels(hi_max));
      end
    end
  endtask

  initial begin
    rst_ni                 = 1'b0;
    tick_if.valid          = 1'b0;
    tick_if.sensor_one_n   = 1'b1;
    tick_if.sensor_two_n   = 1'b1;
    tick_if.sensor_three_n = 1'b1;
    status_if.ready        = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_on_defaults();
    test_trigger_and_overflow();
    test_zero_length_jobs();
    test_register_extremes();
    test_random_traffic();

    wait_drained();
    if (expected_status.size() != 0)
      flag_mismatch("results never returned", 0, expected_status.size());
    $display("covered %0d ticks and %0d results over %0d register writes",
             ticks_sent, results_seen, cfg_writes);
    $display("ring peaked at %0d queued jobs, %0d ticks dropped a job, %0d mismatches",
             peak_queue, drops_expected, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== triggered_stepper_task_queue.f =====
sv/tsq_pkg.sv
sv/tsq_in_if.sv
sv/tsq_out_if.sv
sv/tsq_front.sv
sv/tsq_link.sv
sv/tsq_back.sv
sv/triggered_stepper_task_queue.sv
dv/tb_triggered_stepper_task_queue.sv
